>>> rtl/core/mnu_pkg.sv
package mnu_pkg;

  localparam int ELEM_W       = 16;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 31;
  localparam int ABS_TOTAL_W  = 28;
  localparam int SQ_TOTAL_W   = 42;
  localparam int SUM_W        = 22;
  localparam int ROOT_W       = 21;
  localparam int SQRT_STEPS   = 21;
  localparam int CNT_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;
  localparam int QUEUE_DEPTH  = 4;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
    logic             first_col;
    logic             last_col;
    logic             first_row;
    logic             last_row;
  } item_t;

  function automatic logic [SUM_W-1:0] add_sat22(logic [SUM_W-1:0] a, logic [MAG_W-1:0] b);
    logic [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/core/mnu_if.sv
interface mnu_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mnu_pkg::ELEM_W-1:0] element_value;
  modport source (output valid, element_value, input ready);
  modport sink (input valid, element_value, output ready);
endinterface

interface mnu_out_if;
  logic                               valid;
  logic                               ready;
  logic [mnu_pkg::ABS_TOTAL_W-1:0]    entry_abs_sum;
  logic [mnu_pkg::MAG_W-1:0]          max_abs_entry;
  logic [mnu_pkg::SUM_W-1:0]          frobenius_norm;
  logic [mnu_pkg::SUM_W-1:0]          max_col_abs_sum;
  logic [mnu_pkg::SUM_W-1:0]          max_row_abs_sum;
  modport source (output valid, entry_abs_sum, max_abs_entry, frobenius_norm,
                  max_col_abs_sum, max_row_abs_sum, input ready);
  modport sink (input valid, entry_abs_sum, max_abs_entry, frobenius_norm,
                max_col_abs_sum, max_row_abs_sum, output ready);
endinterface

interface mnu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mnu_pkg::CFG_IDX_W-1:0]    index;
  logic [mnu_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mnu_queue.sv
module mnu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mnu_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output mnu_pkg::item_t head,
  output logic           not_empty
);

  localparam int DEPTH = mnu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mnu_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/mnu_front.sv
module mnu_front #(
  parameter int MAX_COLS = mnu_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mnu_pkg::DEF_MAX_ROWS
) (
  input  logic            clk,
  input  logic            rst_n,
  mnu_in_if.sink          in_ch,
  mnu_cfg_if.sink         cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output mnu_pkg::item_t  q_item,
  output logic            stream_clear
);

  localparam int CW    = mnu_pkg::CNT_W;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CW-1:0]             row_cnt_r, col_cnt_r;
  logic [COL_W-1:0]          col_idx_r, col_idx_nxt;
  logic [ROW_W-1:0]          row_idx_r, row_idx_nxt;
  logic [mnu_pkg::MAG_W-1:0] mag;
  logic [mnu_pkg::SQ_W-1:0]  prod;
  logic                      last_col, last_row, accept, cfg_wr;

  function automatic logic [CW-1:0] clamp_cnt(logic [CW-1:0] v, int maxv);
    if (v == '0) begin
      return CW'(1);
    end else if (int'(v) > maxv) begin
      return CW'(maxv);
    end
    return v;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign stream_clear = cfg_wr && ((cfg_ch.index == mnu_pkg::CFG_ROW_COUNT) ||
                                   (cfg_ch.index == mnu_pkg::CFG_COL_COUNT));

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    mag = in_ch.element_value[mnu_pkg::ELEM_W-1]
        ? (~in_ch.element_value + mnu_pkg::ELEM_W'(1)) : in_ch.element_value;
    prod     = mnu_pkg::SQ_W'(mag) * mnu_pkg::SQ_W'(mag);
    last_col = (32'(col_idx_r) + 32'd1) == 32'(col_cnt_r);
    last_row = (32'(row_idx_r) + 32'd1) == 32'(row_cnt_r);
    q_item.mag       = mag;
    q_item.sq        = prod;
    q_item.first_col = (col_idx_r == '0);
    q_item.last_col  = last_col;
    q_item.first_row = (row_idx_r == '0);
    q_item.last_row  = last_row;
    col_idx_nxt = last_col ? '0 : col_idx_r + COL_W'(1);
    row_idx_nxt = row_idx_r;
    if (last_col) begin
      row_idx_nxt = last_row ? '0 : row_idx_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= CW'(1);
      col_cnt_r <= CW'(1);
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else if (stream_clear) begin
      if (cfg_ch.index == mnu_pkg::CFG_ROW_COUNT) begin
        row_cnt_r <= clamp_cnt(cfg_ch.data, MAX_ROWS);
      end else begin
        col_cnt_r <= clamp_cnt(cfg_ch.data, MAX_COLS);
      end
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else if (accept) begin
      col_idx_r <= col_idx_nxt;
      row_idx_r <= row_idx_nxt;
    end
  end

endmodule

>>> rtl/core/mnu_sqrt.sv
module mnu_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mnu_pkg::SQ_TOTAL_W-1:0]   radicand,
  output logic                             busy,
  output logic                             done,
  output logic [mnu_pkg::ROOT_W-1:0]       root
);

  localparam int XW    = mnu_pkg::SQ_TOTAL_W;
  localparam int RW    = mnu_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int STEPS = mnu_pkg::SQRT_STEPS;
  localparam int CNT_W = $clog2(STEPS);

  logic [XW-1:0]    x_r;
  logic [REM_W-1:0] rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [REM_W+1:0] rem2, trial;
  logic             ge;

  // one result bit per cycle, two radicand bits consumed per step
  always_comb begin
    rem2  = {rem_r, x_r[XW-1 -: 2]};
    trial = (REM_W+2)'({root_r, 2'b01});
    ge    = (rem2 >= trial);
  end

  assign busy = busy_r || done_r;
  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (32'(cnt_r) == STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[XW-3:0], 2'b00};
      rem_r  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
      root_r <= {root_r[RW-2:0], ge};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

endmodule

>>> rtl/core/mnu_back.sv
module mnu_back #(
  parameter int MAX_COLS = mnu_pkg::DEF_MAX_COLS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            stream_clear,
  input  logic            q_not_empty,
  input  mnu_pkg::item_t  q_head,
  output logic            q_pop,
  mnu_out_if.source       out_ch
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = mnu_pkg::ABS_TOTAL_W;
  localparam int QW    = mnu_pkg::SQ_TOTAL_W;
  localparam int SW    = mnu_pkg::SUM_W;
  localparam int MW    = mnu_pkg::MAG_W;

  logic [SW-1:0]    col_mem [MAX_COLS];
  logic [SW-1:0]    rd_data_r;
  logic [COL_W-1:0] col_ptr_r, rd_col;

  logic             s2_valid_r;
  mnu_pkg::item_t   s2_item_r;
  logic [COL_W-1:0] s2_col_r;
  logic             fwd_valid_r;
  logic [COL_W-1:0] fwd_col_r;
  logic [SW-1:0]    fwd_data_r;

  logic [AW-1:0] abs_total_r, abs_total_nxt;
  logic [MW-1:0] abs_peak_r, abs_peak_nxt;
  logic [QW-1:0] sq_total_r, sq_total_nxt;
  logic [SW-1:0] row_sum_r, row_sum_nxt;
  logic [SW-1:0] row_peak_r, row_peak_nxt;
  logic [SW-1:0] col_peak_r, col_peak_nxt;
  logic [SW-1:0] col_base, col_sum_nxt;
  logic [AW:0]   abs_sum;
  logic [QW:0]   sq_sum;
  logic          matrix_done, fin_busy, sqrt_busy, sqrt_done, sqrt_start;
  logic [mnu_pkg::ROOT_W-1:0] sqrt_root;

  logic [AW-1:0] fin_abs_total_r;
  logic [MW-1:0] fin_abs_peak_r;
  logic [SW-1:0] fin_row_peak_r, fin_col_peak_r;

  logic          out_valid_r;
  logic [AW-1:0] out_abs_total_r;
  logic [MW-1:0] out_abs_peak_r;
  logic [SW-1:0] out_frob_r, out_col_peak_r, out_row_peak_r;

  // a matrix end may only enter the pipe when the finishing path is free
  assign fin_busy = sqrt_busy || out_valid_r ||
                    (s2_valid_r && s2_item_r.last_col && s2_item_r.last_row);
  assign q_pop    = q_not_empty &&
                    !(q_head.last_col && q_head.last_row && fin_busy);
  assign rd_col   = q_head.first_col ? '0 : col_ptr_r + COL_W'(1);

  always_comb begin
    matrix_done   = s2_item_r.last_col && s2_item_r.last_row;
    abs_sum       = (AW+1)'(abs_total_r) + (AW+1)'(s2_item_r.mag);
    abs_total_nxt = abs_sum[AW] ? {AW{1'b1}} : abs_sum[AW-1:0];
    abs_peak_nxt  = (s2_item_r.mag > abs_peak_r) ? s2_item_r.mag : abs_peak_r;
    sq_sum        = (QW+1)'(sq_total_r) + (QW+1)'(s2_item_r.sq);
    sq_total_nxt  = sq_sum[QW] ? {QW{1'b1}} : sq_sum[QW-1:0];
    row_sum_nxt   = s2_item_r.first_col ? SW'(s2_item_r.mag)
                  : mnu_pkg::add_sat22(row_sum_r, s2_item_r.mag);
    row_peak_nxt  = (s2_item_r.last_col && (row_sum_nxt > row_peak_r))
                  ? row_sum_nxt : row_peak_r;
    // write from the previous cycle has not reached the registered read
    col_base      = (fwd_valid_r && (fwd_col_r == s2_col_r)) ? fwd_data_r : rd_data_r;
    col_sum_nxt   = s2_item_r.first_row ? SW'(s2_item_r.mag)
                  : mnu_pkg::add_sat22(col_base, s2_item_r.mag);
    col_peak_nxt  = (s2_item_r.last_row && (col_sum_nxt > col_peak_r))
                  ? col_sum_nxt : col_peak_r;
    sqrt_start    = s2_valid_r && matrix_done;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r <= col_mem[rd_col];
    end
    if (s2_valid_r) begin
      col_mem[s2_col_r] <= col_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      abs_total_r <= '0;
      abs_peak_r  <= '0;
      sq_total_r  <= '0;
      row_sum_r   <= '0;
      row_peak_r  <= '0;
      col_peak_r  <= '0;
    end else begin
      s2_valid_r  <= q_pop;
      fwd_valid_r <= s2_valid_r;
      priority if (stream_clear || sqrt_start) begin
        abs_total_r <= '0;
        abs_peak_r  <= '0;
        sq_total_r  <= '0;
        row_sum_r   <= '0;
        row_peak_r  <= '0;
        col_peak_r  <= '0;
      end else if (s2_valid_r) begin
        abs_total_r <= abs_total_nxt;
        abs_peak_r  <= abs_peak_nxt;
        sq_total_r  <= sq_total_nxt;
        row_sum_r   <= row_sum_nxt;
        row_peak_r  <= row_peak_nxt;
        col_peak_r  <= col_peak_nxt;
      end else begin
        abs_total_r <= abs_total_r;
        abs_peak_r  <= abs_peak_r;
        sq_total_r  <= sq_total_r;
        row_sum_r   <= row_sum_r;
        row_peak_r  <= row_peak_r;
        col_peak_r  <= col_peak_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_item_r <= q_head;
      s2_col_r  <= rd_col;
      col_ptr_r <= rd_col;
    end
    fwd_col_r  <= s2_col_r;
    fwd_data_r <= col_sum_nxt;
    if (sqrt_start) begin
      fin_abs_total_r <= abs_total_nxt;
      fin_abs_peak_r  <= abs_peak_nxt;
      fin_row_peak_r  <= row_peak_nxt;
      fin_col_peak_r  <= col_peak_nxt;
    end
    if (sqrt_done) begin
      out_abs_total_r <= fin_abs_total_r;
      out_abs_peak_r  <= fin_abs_peak_r;
      out_frob_r      <= SW'(sqrt_root);
      out_col_peak_r  <= fin_col_peak_r;
      out_row_peak_r  <= fin_row_peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sqrt_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  mnu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_total_nxt),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.entry_abs_sum   = out_abs_total_r;
  assign out_ch.max_abs_entry   = out_abs_peak_r;
  assign out_ch.frobenius_norm  = out_frob_r;
  assign out_ch.max_col_abs_sum = out_col_peak_r;
  assign out_ch.max_row_abs_sum = out_row_peak_r;

endmodule

>>> rtl/core/matrix_norm_unit_top.sv
// Streaming matrix norms.
// in_ch  : one signed Q8.8 entry per item, row-major; ready drops only when
//          the four-entry queue to the accumulators is full.
// cfg_ch : index 0 = row count, index 1 = column count (0 acts as 1, values
//          above MAX_ROWS / MAX_COLS clamp). Any such write restarts the matrix.
//          Always ready; write only while no matrix is in progress.
// out_ch : one item per matrix with abs sum, peak |a|, Frobenius norm, and the
//          largest column and row absolute sums.
// Throughput: one entry per cycle within a matrix. The last entry of a matrix
// waits in the queue while the previous result is still being finished or has
// not been taken.
// Result: the last entry of a matrix starts the 21-step bit-serial square root
// from the accumulator stage; the norms are registered onto out_ch when it ends.
// Reset: counts return to 1, all sums clear; column sums are written in row 0
// and need no clearing.
// A stalled out_ch holds its item; entries keep flowing until the next matrix
// end reaches the head of the queue.
module matrix_norm_unit_top #(
  parameter int MAX_COLS = mnu_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = mnu_pkg::DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  mnu_in_if.sink      in_ch,
  mnu_out_if.source   out_ch,
  mnu_cfg_if.sink     cfg_ch
);

  logic           q_push, q_full, q_pop, q_not_empty, stream_clear;
  mnu_pkg::item_t q_item, q_head;

  mnu_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item),
    .stream_clear (stream_clear)
  );

  mnu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  mnu_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .stream_clear (stream_clear),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

endmodule

>>> rtl/core/mnu_checker.sv
module mnu_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [mnu_pkg::ABS_TOTAL_W-1:0]    entry_abs_sum,
  input logic [mnu_pkg::MAG_W-1:0]          max_abs_entry,
  input logic [mnu_pkg::SUM_W-1:0]          frobenius_norm,
  input logic [mnu_pkg::SUM_W-1:0]          max_col_abs_sum,
  input logic [mnu_pkg::SUM_W-1:0]          max_row_abs_sum
);

  localparam int AW = mnu_pkg::ABS_TOTAL_W;
  localparam int SW = mnu_pkg::SUM_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(entry_abs_sum) && $stable(frobenius_norm) &&
      $stable(max_abs_entry) && $stable(max_col_abs_sum) && $stable(max_row_abs_sum))
    else $error("result changed while stalled");

  a_frob_ge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> frobenius_norm >= SW'(max_abs_entry))
    else $error("Frobenius norm below largest entry");

  a_lines_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (AW'(max_row_abs_sum) <= entry_abs_sum) &&
      (AW'(max_col_abs_sum) <= entry_abs_sum))
    else $error("row or column sum above total");

endmodule

bind matrix_norm_unit_top mnu_checker u_mnu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .entry_abs_sum   (out_ch.entry_abs_sum),
  .max_abs_entry   (out_ch.max_abs_entry),
  .frobenius_norm  (out_ch.frobenius_norm),
  .max_col_abs_sum (out_ch.max_col_abs_sum),
  .max_row_abs_sum (out_ch.max_row_abs_sum)
);

>>> tb/sv/matrix_norm_unit_top_test.sv
`timescale 1ns / 100ps

module matrix_norm_unit_top_test;
  import mnu_pkg::*;

  localparam int          COUNT_CAP    = DEF_MAX_ROWS;
  localparam int          COUNT_TOP    = (1 << CNT_W) - 1;
  localparam int unsigned SPARE_INDEX  = 2;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 420;
  localparam int          QUIET_AFTER  = 340;
  localparam int          MULTI_CAP    = 16;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

  typedef struct packed {
    logic [ABS_TOTAL_W-1:0] entry_abs_sum;
    logic [MAG_W-1:0]       max_abs_entry;
    logic [SUM_W-1:0]       frobenius_norm;
    logic [SUM_W-1:0]       max_col_abs_sum;
    logic [SUM_W-1:0]       max_row_abs_sum;
  } norms_t;

  class norm_scoreboard;
    logic [CNT_W-1:0]       row_reg;
    logic [CNT_W-1:0]       col_reg;
    int unsigned            row_pos;
    int unsigned            col_pos;
    logic [ABS_TOTAL_W-1:0] abs_sum;
    logic [MAG_W-1:0]       abs_max;
    logic [SQ_TOTAL_W-1:0]  square_sum;
    logic [SUM_W-1:0]       row_run;
    logic [SUM_W-1:0]       row_best;
    logic [SUM_W-1:0]       col_best;
    logic [SUM_W-1:0]       col_acc [DEF_MAX_COLS];
    norms_t                 expected_norms [$];
    int                     fails;

    function new();
      row_reg = 1;
      col_reg = 1;
      fails = 0;
      restart();
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      abs_sum = '0;
      abs_max = '0;
      square_sum = '0;
      row_run = '0;
      row_best = '0;
      col_best = '0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                      longint unsigned lim);
      longint unsigned s;
      s = a + b;
      return (s > lim) ? lim : s;
    endfunction

    function int unsigned eff_count(logic [CNT_W-1:0] v, int unsigned cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : v;
    endfunction

    function logic [SUM_W-1:0] floor_root(logic [SQ_TOTAL_W-1:0] v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = ROOT_W; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return SUM_W'(r);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_ROW_COUNT) row_reg = val;
      else if (idx == CFG_COL_COUNT) col_reg = val;
      else return;
      restart();
    endfunction

    function void note_entry(logic signed [ELEM_W-1:0] v);
      int unsigned rows;
      int unsigned cols;
      int unsigned mag;
      logic [SUM_W-1:0] cs;
      norms_t n;
      rows = eff_count(row_reg, DEF_MAX_ROWS);
      cols = eff_count(col_reg, DEF_MAX_COLS);
      mag = (v < 0) ? -int'(v) : int'(v);
      abs_sum = ABS_TOTAL_W'(sat_add(abs_sum, mag, {ABS_TOTAL_W{1'b1}}));
      if (mag > abs_max) abs_max = MAG_W'(mag);
      square_sum = SQ_TOTAL_W'(sat_add(square_sum, longint'(mag) * mag,
                                       {SQ_TOTAL_W{1'b1}}));
      row_run = (col_pos == 0) ? SUM_W'(mag) : SUM_W'(sat_add(row_run, mag, {SUM_W{1'b1}}));
      if (col_pos + 1 == cols && row_run > row_best) row_best = row_run;
      cs = (row_pos == 0) ? SUM_W'(mag)
                          : SUM_W'(sat_add(col_acc[col_pos], mag, {SUM_W{1'b1}}));
      col_acc[col_pos] = cs;
      if (row_pos + 1 == rows && cs > col_best) col_best = cs;
      if (col_pos + 1 != cols) begin
        col_pos++;
        return;
      end
      col_pos = 0;
      if (row_pos + 1 != rows) begin
        row_pos++;
        return;
      end
      n.entry_abs_sum = abs_sum;
      n.max_abs_entry = abs_max;
      n.frobenius_norm = floor_root(square_sum);
      n.max_col_abs_sum = col_best;
      n.max_row_abs_sum = row_best;
      expected_norms.push_back(n);
      restart();
    endfunction

    function void check_result(norms_t got);
      norms_t exp_n;
      if (expected_norms.size() == 0) begin
        $error("unexpected result item");
        fails++;
        return;
      end
      exp_n = expected_norms.pop_front();
      if (got.entry_abs_sum !== exp_n.entry_abs_sum) begin
        $error("entry_abs_sum: expected %0d, got %0d", exp_n.entry_abs_sum, got.entry_abs_sum);
        fails++;
      end
      if (got.max_abs_entry !== exp_n.max_abs_entry) begin
        $error("max_abs_entry: expected %0d, got %0d", exp_n.max_abs_entry, got.max_abs_entry);
        fails++;
      end
      if (got.frobenius_norm !== exp_n.frobenius_norm) begin
        $error("frobenius_norm: expected %0d, got %0d",
               exp_n.frobenius_norm, got.frobenius_norm);
        fails++;
      end
      if (got.max_col_abs_sum !== exp_n.max_col_abs_sum) begin
        $error("max_col_abs_sum: expected %0d, got %0d",
               exp_n.max_col_abs_sum, got.max_col_abs_sum);
        fails++;
      end
      if (got.max_row_abs_sum !== exp_n.max_row_abs_sum) begin
        $error("max_row_abs_sum: expected %0d, got %0d",
               exp_n.max_row_abs_sum, got.max_row_abs_sum);
        fails++;
      end
    endfunction

    function int pending();
      return expected_norms.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  bit   in_idle_on;
  int   cycle_count;

  norm_scoreboard sb = new();

  mnu_in_if  in_bus ();
  mnu_out_if out_bus ();
  mnu_cfg_if cfg_bus ();

  matrix_norm_unit_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("matrix_norm_unit_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) sb.note_entry(in_bus.element_value);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
  end

  always @(posedge clk) begin
    norms_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.entry_abs_sum = out_bus.entry_abs_sum;
      got.max_abs_entry = out_bus.max_abs_entry;
      got.frobenius_norm = out_bus.frobenius_norm;
      got.max_col_abs_sum = out_bus.max_col_abs_sum;
      got.max_row_abs_sum = out_bus.max_row_abs_sum;
      sb.check_result(got);
    end
  end

  // result-side backpressure
  initial begin
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet) begin
        out_bus.ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
        if (!quiet) begin
          out_bus.ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk);
        end
      end
    end
  end

  task automatic send_entry(input logic signed [ELEM_W-1:0] v);
    if (!quiet && in_idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.element_value <= v;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // writes to the unused indexes must leave the matrix state alone
  task automatic configure(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    wait_idle();
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(SPARE_INDEX, (1 << CFG_IDX_W) - 1)), 7'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_ROW_COUNT, rows);
      write_reg(CFG_COL_COUNT, cols);
    end else begin
      write_reg(CFG_COL_COUNT, cols);
      write_reg(CFG_ROW_COUNT, rows);
    end
    in_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_entry();
    int m;
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: begin
        m = $urandom_range(0, 512);
        return $urandom_range(0, 1) ? ELEM_W'(-m) : ELEM_W'(m);
      end
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CNT_W'($urandom_range(COUNT_CAP, COUNT_TOP));
      default: return CNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int eff(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    return (v > COUNT_CAP) ? COUNT_CAP : v;
  endfunction

  initial begin
    int               entries [$];
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    int               mats;
    int               random_items;
    quiet = 1'b0;
    in_idle_on = 1'b1;
    cycle_count = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.element_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ROW_COUNT;
    cfg_bus.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes: every entry is a 1x1 matrix
    entries = '{0, 32767, -32768, -1, 1};
    foreach (entries[i]) send_entry(ELEM_W'(entries[i]));
    configure('0, '0);
    entries = '{256, -256};
    foreach (entries[i]) send_entry(ELEM_W'(entries[i]));
    configure(2, 3);
    entries = '{32767, -32768, 0, -1, 1, 256};
    foreach (entries[i]) send_entry(ELEM_W'(entries[i]));
    configure(3, 1);
    entries = '{-32768, -32768, 12345};
    foreach (entries[i]) send_entry(ELEM_W'(entries[i]));
    configure(1, 4);
    entries = '{-100, 200, -300, 400};
    foreach (entries[i]) send_entry(ELEM_W'(entries[i]));
    configure(1, CNT_W'(COUNT_TOP));
    repeat (COUNT_CAP) send_entry(pick_entry());

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      rows = pick_count();
      cols = pick_count();
      if (eff(rows) * eff(cols) > COUNT_CAP) begin
        if (eff(rows) > eff(cols)) cols = CNT_W'(1);
        else rows = CNT_W'(1);
      end
      configure(rows, cols);
      if (random_items >= QUIET_AFTER) quiet = 1'b1;
      mats = (eff(rows) * eff(cols) > MULTI_CAP) ? 1 : $urandom_range(1, 4);
      repeat (mats) begin
        repeat (eff(rows) * eff(cols)) begin
          send_entry(pick_entry());
          random_items++;
        end
      end
    end

    wait_idle();
    if (sb.fails == 0) begin
      $display("matrix_norm_unit_top regression: pass");
    end else begin
      $display("matrix_norm_unit_top regression: fail");
    end
    $finish;
  end

endmodule
